// File: rtl/core/positional_array_list_top_macros.svh
// Assertion macros for the positional array list checks
`ifndef POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PAL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PAL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pal_pkg.sv
// Shared types and constants for the positional array list
package pal_pkg;

  localparam int OP_W  = 2;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int LEN_W = 5;

  localparam logic [OP_W-1:0] OP_GET    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOCATE = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

  // index register load sources
  localparam logic [1:0] IDX_ZERO = 2'd0;
  localparam logic [1:0] IDX_POS  = 2'd1;
  localparam logic [1:0] IDX_LAST = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       load_idx;
    logic [1:0] idx_sel;
    logic       idx_inc;
    logic       idx_dec;
    logic       rd_en;
    logic       wr_move_up;
    logic       wr_move_down;
    logic       wr_value;
    logic       take_rd;
    logic       set_ok;
    logic       set_found;
    logic       cnt_inc;
    logic       cnt_dec;
  } pal_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            get_ok;
    logic            ins_ok;
    logic            ins_has_move;
    logic            list_empty;
    logic            idx_at_end;
    logic            idx_at_pos;
    logic            hit;
  } pal_sts_t;

endpackage

// File: rtl/core/pal_dpath.sv
// Datapath: entry memory, count, index register and result registers
module pal_dpath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pal_pkg::pal_cmd_t        cmd,
  input  logic [pal_pkg::OP_W-1:0] in_operation,
  input  logic [pal_pkg::POS_W-1:0] in_position,
  input  logic [pal_pkg::VAL_W-1:0] in_value,
  output pal_pkg::pal_sts_t        sts,
  output logic                     out_ok,
  output logic [pal_pkg::VAL_W-1:0] out_read_value,
  output logic [pal_pkg::POS_W-1:0] out_found_position,
  output logic [pal_pkg::LEN_W-1:0] out_list_length,
  output logic                     out_is_empty
);
  import pal_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [OP_W-1:0]       op_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  res_ok_r;
  logic [DATA_WIDTH-1:0] res_rd_r;
  logic [POS_W-1:0]      res_found_r;

  logic [CMPW-1:0]       pos_x, cnt_x, idx_x, depth_x;
  logic [AW-1:0]         idx_a, pos_a, waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  we;

  always_comb begin
    pos_x   = CMPW'(pos_r);
    cnt_x   = CMPW'(count_r);
    idx_x   = CMPW'(idx_r);
    depth_x = CMPW'(DEPTH);
    idx_a   = idx_r[AW-1:0];
    pos_a   = AW'(pos_x - CMPW'(1));

    sts.op           = op_r;
    sts.get_ok       = (pos_x != '0) && (pos_x <= cnt_x);
    sts.ins_ok       = (cnt_x < depth_x) && (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1));
    sts.ins_has_move = (pos_x <= cnt_x);
    sts.list_empty   = (count_r == '0);
    sts.idx_at_end   = (idx_x + CMPW'(1) == cnt_x);
    sts.idx_at_pos   = (idx_x + CMPW'(1) == pos_x);
    sts.hit          = (rdata_r == val_r);
  end

  // single write port: shift move or new value
  always_comb begin
    we    = cmd.wr_move_up | cmd.wr_move_down | cmd.wr_value;
    waddr = pos_a;
    wdata = val_r;
    if (cmd.wr_move_up) begin
      waddr = AW'(idx_a + AW'(1));
      wdata = rdata_r;
    end else if (cmd.wr_move_down) begin
      waddr = AW'(idx_a - AW'(1));
      wdata = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[idx_a];
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load_idx) begin
      unique case (cmd.idx_sel)
        IDX_ZERO: idx_nxt = '0;
        IDX_POS:  idx_nxt = CW'(pos_x - CMPW'(1));
        IDX_LAST: idx_nxt = CW'(cnt_x - CMPW'(1));
        default:  idx_nxt = '0;
      endcase
    end else if (cmd.idx_inc) begin
      idx_nxt = CW'(idx_x + CMPW'(1));
    end else if (cmd.idx_dec) begin
      idx_nxt = CW'(idx_x - CMPW'(1));
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = CW'(cnt_x + CMPW'(1));
    end else if (cmd.cnt_dec) begin
      count_nxt = CW'(cnt_x - CMPW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= in_operation;
      pos_r       <= in_position;
      val_r       <= DATA_WIDTH'(in_value);
      res_ok_r    <= 1'b0;
      res_rd_r    <= '0;
      res_found_r <= '0;
    end else begin
      if (cmd.set_ok) begin
        res_ok_r <= 1'b1;
      end
      if (cmd.take_rd) begin
        res_rd_r <= rdata_r;
      end
      if (cmd.set_found) begin
        res_found_r <= POS_W'(idx_x + CMPW'(1));
      end
    end
  end

  assign out_ok             = res_ok_r;
  assign out_read_value     = VAL_W'(res_rd_r);
  assign out_found_position = res_found_r;
  assign out_list_length    = LEN_W'(count_r);
  assign out_is_empty       = sts.list_empty;

endmodule

// File: rtl/core/pal_ctrl.sv
// Controller: sequences each operation over the datapath
module pal_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pal_pkg::pal_sts_t  sts,
  output pal_pkg::pal_cmd_t  cmd,
  output logic               busy,
  output logic               out_strobe
);
  import pal_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_GET_RD  = 4'd2;
  localparam logic [3:0] S_GET_CAP = 4'd3;
  localparam logic [3:0] S_LOC_RD  = 4'd4;
  localparam logic [3:0] S_LOC_CMP = 4'd5;
  localparam logic [3:0] S_INS_RD  = 4'd6;
  localparam logic [3:0] S_INS_MV  = 4'd7;
  localparam logic [3:0] S_INS_PUT = 4'd8;
  localparam logic [3:0] S_DEL_RD  = 4'd9;
  localparam logic [3:0] S_DEL_CAP = 4'd10;
  localparam logic [3:0] S_DEL_MRD = 4'd11;
  localparam logic [3:0] S_DEL_MV  = 4'd12;
  localparam logic [3:0] S_RESULT  = 4'd13;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op)
          OP_GET: begin
            if (sts.get_ok) begin
              cmd.load_idx = 1'b1;
              cmd.idx_sel  = IDX_POS;
              state_nxt    = S_GET_RD;
            end else begin
              state_nxt = S_RESULT;
            end
          end
          OP_LOCATE: begin
            cmd.set_ok = 1'b1;
            if (sts.list_empty) begin
              state_nxt = S_RESULT;
            end else begin
              cmd.load_idx = 1'b1;
              cmd.idx_sel  = IDX_ZERO;
              state_nxt    = S_LOC_RD;
            end
          end
          OP_INSERT: begin
            if (!sts.ins_ok) begin
              state_nxt = S_RESULT;
            end else if (sts.ins_has_move) begin
              cmd.load_idx = 1'b1;
              cmd.idx_sel  = IDX_LAST;
              state_nxt    = S_INS_RD;
            end else begin
              state_nxt = S_INS_PUT;
            end
          end
          OP_DELETE: begin
            if (sts.get_ok) begin
              cmd.load_idx = 1'b1;
              cmd.idx_sel  = IDX_POS;
              state_nxt    = S_DEL_RD;
            end else begin
              state_nxt = S_RESULT;
            end
          end
        endcase
      end
      S_GET_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_GET_CAP;
      end
      S_GET_CAP: begin
        cmd.take_rd = 1'b1;
        cmd.set_ok  = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_LOC_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOC_CMP;
      end
      S_LOC_CMP: begin
        if (sts.hit) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_RESULT;
        end else if (sts.idx_at_end) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_LOC_RD;
        end
      end
      S_INS_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_INS_MV;
      end
      S_INS_MV: begin
        cmd.wr_move_up = 1'b1;
        if (sts.idx_at_pos) begin
          state_nxt = S_INS_PUT;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_INS_RD;
        end
      end
      S_INS_PUT: begin
        cmd.wr_value = 1'b1;
        cmd.cnt_inc  = 1'b1;
        cmd.set_ok   = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_DEL_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd.take_rd = 1'b1;
        cmd.set_ok  = 1'b1;
        if (sts.idx_at_end) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_DEL_MRD;
        end
      end
      S_DEL_MRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DEL_MV;
      end
      S_DEL_MV: begin
        cmd.wr_move_down = 1'b1;
        if (sts.idx_at_end) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_DEL_MRD;
        end
      end
      S_RESULT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_RESULT);

endmodule

// File: rtl/core/positional_array_list_top.sv
// Top level of the positional array list: controller plus datapath
// Sequence from accept to strobe: a bad position goes straight to the result state; get
//   reads then captures; locate reads and compares each entry; insert shifts entries up, then
//   writes the value; delete reads the word, then shifts later entries down, a read then a
//   write/compare per step. A new word is taken only after the strobe, once busy is low.
// Reset (rst_n low, synchronous) empties the list; the receiver cannot stall.
module positional_array_list_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command side
  input  logic                      start,
  output logic                      busy,
  input  logic [pal_pkg::OP_W-1:0]  in_operation,
  input  logic [pal_pkg::POS_W-1:0] in_position,
  input  logic [pal_pkg::VAL_W-1:0] in_value,
  // result side
  output logic                      out_strobe,
  output logic                      out_ok,
  output logic [pal_pkg::VAL_W-1:0] out_read_value,
  output logic [pal_pkg::POS_W-1:0] out_found_position,
  output logic [pal_pkg::LEN_W-1:0] out_list_length,
  output logic                      out_is_empty
);
  import pal_pkg::*;

  pal_cmd_t cmd;
  pal_sts_t sts;

  // controller: one state per memory access, loops for shifting and search
  pal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // datapath: entry memory, count, walking index and result word registers
  pal_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .sts                (sts),
    .out_ok             (out_ok),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length),
    .out_is_empty       (out_is_empty)
  );

endmodule

// File: rtl/core/pal_chk.sv
// Port-level checker for the positional array list, bound to the top level
`include "positional_array_list_top_macros.svh"

module pal_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_strobe,
  input logic                      out_ok,
  input logic [pal_pkg::VAL_W-1:0] out_read_value,
  input logic [pal_pkg::POS_W-1:0] out_found_position,
  input logic [pal_pkg::LEN_W-1:0] out_list_length,
  input logic                      out_is_empty
);

  `PAL_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
  `PAL_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_strobe, busy, "result word outside busy")
  `PAL_ASSERT_NXT(a_strobe_pulse, clk, rst_n, out_strobe, !out_strobe && !busy, "result word held over")
  `PAL_ASSERT_IMP(a_fail_clean, clk, rst_n, out_strobe && !out_ok, (out_read_value == '0) && (out_found_position == '0), "failed word carries data")
  `PAL_ASSERT_IMP(a_empty_len, clk, rst_n, out_strobe && out_is_empty, out_list_length == '0, "empty list with non-zero length")

endmodule

bind positional_array_list_top pal_chk u_pal_chk (.*);

// File: tb/tb_positional_array_list_top.sv
// Self-checking testbench for the positional array list top level
`timescale 1ns / 1ps

module tb_positional_array_list_top;
  import pal_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;

  // one expected result word
  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] read_value;
    logic [POS_W-1:0] found_position;
    logic [LEN_W-1:0] list_length;
    logic             is_empty;
  } list_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [OP_W-1:0]  in_operation = OP_GET;
  logic [POS_W-1:0] in_position = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic             out_strobe;
  logic             out_ok;
  logic [VAL_W-1:0] out_read_value;
  logic [POS_W-1:0] out_found_position;
  logic [LEN_W-1:0] out_list_length;
  logic             out_is_empty;

  // mirror of the list contents, kept by the predictor
  logic [VAL_W-1:0] mirror_words [LIST_DEPTH];
  int               mirror_count;

  list_result_t     pending_results [$];

  int error_count;
  int checked_count;
  int cycle_count;
  int op_count [4];
  int ok_count;
  int locate_hits;
  int full_seen;
  int empty_seen;
  bit gaps_on;

  // small pool of values so that locate finds duplicates and hits often
  logic [VAL_W-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                       32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                       32'h0000_00FF, 32'h1234_5678};

  positional_array_list_top #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (32)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_strobe         (out_strobe),
    .out_ok             (out_ok),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length),
    .out_is_empty       (out_is_empty)
  );

  always #5 clk = ~clk;

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Applies one operation to the mirror and returns the result the block owes.
  // Bad positions and a full list leave the mirror untouched.
  function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                 logic [POS_W-1:0] pos_in,
                                                 logic [VAL_W-1:0] val);
    list_result_t res;
    int           pos;
    int           k;
    res = '0;
    pos = int'(pos_in);
    case (op)
      OP_GET: begin
        if (pos >= 1 && pos <= mirror_count) begin
          res.read_value = mirror_words[pos-1];
          res.ok = 1'b1;
        end
      end
      OP_LOCATE: begin
        res.ok = 1'b1;
        for (k = 0; k < mirror_count; k++) begin
          if (mirror_words[k] == val) begin
            res.found_position = POS_W'(k + 1);
            break;
          end
        end
      end
      OP_INSERT: begin
        if (mirror_count < LIST_DEPTH && pos >= 1 && pos <= mirror_count + 1) begin
          for (k = mirror_count; k >= pos; k--)
            mirror_words[k] = mirror_words[k-1];
          mirror_words[pos-1] = val;
          mirror_count++;
          res.ok = 1'b1;
        end
      end
      default: begin
        if (pos >= 1 && pos <= mirror_count) begin
          res.read_value = mirror_words[pos-1];
          for (k = pos; k < mirror_count; k++)
            mirror_words[k-1] = mirror_words[k];
          mirror_count--;
          res.ok = 1'b1;
        end
      end
    endcase
    res.list_length = LEN_W'(mirror_count);
    res.is_empty = (mirror_count == 0);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("Mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
             checked_count, field, got, want);
    error_count++;
  endtask

  // Result side: every strobe is taken at the edge that closes its cycle.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("Unexpected result word %0d with nothing outstanding", checked_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok)
          report_mismatch("ok", 32'(out_ok), 32'(want.ok));
        if (out_read_value !== want.read_value)
          report_mismatch("read_value", out_read_value, want.read_value);
        if (out_found_position !== want.found_position)
          report_mismatch("found_position", 32'(out_found_position),
                          32'(want.found_position));
        if (out_list_length !== want.list_length)
          report_mismatch("list_length", 32'(out_list_length), 32'(want.list_length));
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(out_is_empty), 32'(want.is_empty));
      end
      checked_count++;
    end
  end

  // Presents one command word and holds it until the block takes it.
  // start is left high so a back-to-back word never drops it for a step.
  task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [VAL_W-1:0] val);
    list_result_t res;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    res = apply_list_op(op, pos, val);
    pending_results.push_back(res);
    op_count[op]++;
    if (res.ok) ok_count++;
    if (op == OP_LOCATE && res.found_position != 0) locate_hits++;
    if (mirror_count == LIST_DEPTH) full_seen++;
    if (mirror_count == 0) empty_seen++;
  endtask

  // Random pause on the command side: mostly none, often short, now and then long.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 45) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 55) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic send_and_pause(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] val);
    send_word(op, pos, val);
    idle_gap();
  endtask

  // Empty list, bad positions, head/middle/tail inserts, duplicates, delete.
  task automatic test_directed_corners();
    send_and_pause(OP_GET, 5'd0, '0);
    send_and_pause(OP_GET, 5'd1, '0);
    send_and_pause(OP_DELETE, 5'd1, '0);
    send_and_pause(OP_LOCATE, 5'd0, 32'h0000_0000);
    send_and_pause(OP_INSERT, 5'd0, 32'hDEAD_BEEF);  // position zero
    send_and_pause(OP_INSERT, 5'd2, 32'hDEAD_BEEF);  // past the end
    send_and_pause(OP_INSERT, 5'd1, 32'hFFFF_FFFF);
    send_and_pause(OP_INSERT, 5'd1, 32'h0000_0000);  // at head
    send_and_pause(OP_INSERT, 5'd3, 32'hA5A5_A5A5);  // at tail
    send_and_pause(OP_INSERT, 5'd2, 32'hFFFF_FFFF);  // middle, duplicate value
    send_and_pause(OP_GET, 5'd1, '0);
    send_and_pause(OP_GET, 5'd4, '0);
    send_and_pause(OP_GET, 5'd5, '0);                // one past length
    send_and_pause(OP_GET, 5'd31, '0);
    send_and_pause(OP_LOCATE, 5'd31, 32'hFFFF_FFFF); // first of two copies
    send_and_pause(OP_LOCATE, 5'd0, 32'h1357_9BDF);  // absent
    send_and_pause(OP_INSERT, 5'd31, 32'h1111_1111);
    send_and_pause(OP_DELETE, 5'd2, '0);             // middle
    send_and_pause(OP_DELETE, 5'd0, '0);
    send_and_pause(OP_DELETE, 5'd31, '0);
    send_and_pause(OP_DELETE, 5'd3, '0);             // tail
    send_and_pause(OP_DELETE, 5'd1, '0);
    send_and_pause(OP_DELETE, 5'd1, '0);             // back to empty
  endtask

  // Fill to capacity, try to overrun, probe the last slot, then drain.
  task automatic test_full_list();
    int k;
    while (mirror_count < LIST_DEPTH)
      send_and_pause(OP_INSERT, POS_W'($urandom_range(1, mirror_count + 1)), pick_value());
    send_and_pause(OP_INSERT, 5'd17, 32'hCAFE_F00D);
    send_and_pause(OP_INSERT, 5'd1, 32'hCAFE_F00D);
    send_and_pause(OP_GET, 5'd16, '0);
    send_and_pause(OP_GET, 5'd17, '0);
    send_and_pause(OP_LOCATE, 5'd0, mirror_words[LIST_DEPTH-1]);
    send_and_pause(OP_LOCATE, 5'd0, 32'hCAFE_F00D);
    send_and_pause(OP_DELETE, 5'd16, '0);
    for (k = 0; k < 6; k++)
      send_and_pause(OP_DELETE, POS_W'($urandom_range(1, mirror_count)), '0);
    while (mirror_count > 0)
      send_and_pause(OP_DELETE, 5'd1, '0);
  endtask

  // Mixed traffic steered to keep the list length wandering across its range.
  task automatic test_random_traffic(int n_words);
    int               i;
    int               r;
    int               ins_weight;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    for (i = 0; i < n_words; i++) begin
      if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      // lean towards inserts when short, deletes when long
      ins_weight = (mirror_count < 4) ? 50 : (mirror_count > 12) ? 20 : 33;
      r = $urandom_range(0, 99);
      if (r < ins_weight) op = OP_INSERT;
      else if (r < ins_weight + 25) op = OP_DELETE;
      else if (r < ins_weight + 45) op = OP_GET;
      else op = OP_LOCATE;

      if ($urandom_range(0, 99) < 12) pos = POS_W'($urandom_range(0, 31));
      else if (op == OP_INSERT) pos = POS_W'($urandom_range(1, mirror_count + 1));
      else if (mirror_count > 0) pos = POS_W'($urandom_range(1, mirror_count));
      else pos = POS_W'($urandom_range(0, 2));

      if (op == OP_LOCATE && mirror_count > 0 && $urandom_range(0, 99) < 65)
        val = mirror_words[$urandom_range(0, mirror_count - 1)];
      else
        val = pick_value();

      send_and_pause(op, pos, val);
    end
  endtask

  initial begin
    error_count = 0;
    checked_count = 0;
    cycle_count = 0;
    ok_count = 0;
    locate_hits = 0;
    full_seen = 0;
    empty_seen = 0;
    op_count = '{default: 0};
    mirror_count = 0;
    mirror_words = '{default: '0};
    gaps_on = 1'b1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_full_list();
    test_random_traffic(390);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words: %0d get, %0d locate, %0d insert, %0d delete; %0d succeeded",
             checked_count, op_count[OP_GET], op_count[OP_LOCATE], op_count[OP_INSERT],
             op_count[OP_DELETE], ok_count);
    $display("Locate hits %0d, list full %0d times, empty %0d times, %0d mismatches",
             locate_hits, full_seen, empty_seen, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pal_pkg.sv
rtl/core/pal_dpath.sv
rtl/core/pal_ctrl.sv
rtl/core/positional_array_list_top.sv
rtl/core/pal_chk.sv
tb/tb_positional_array_list_top.sv
